### hdl/aeft_pkg.sv
// Shared types and constants for the terminal escape filter and cursor tracker.
// Holds the job record passed from the parser to the output sequencer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package aeft_pkg;

  localparam int SEQ_LEN = 10;
  localparam int IDX_W = 4;
  localparam int QUEUE_DEPTH = 2;
  localparam int CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_COLUMNS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_ROWS = 2'd1;

  localparam logic [7:0] COLUMNS_RESET = 8'd80;
  localparam logic [7:0] ROWS_RESET = 8'd25;

  localparam logic [7:0] CH_BEL = 8'h07;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_ESC = 8'h1B;
  localparam logic [7:0] CH_CSI = 8'h9B;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_RBRACKET = 8'h5D;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_QUESTION = 8'h3F;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_LOWER_N = 8'h6E;
  localparam logic [7:0] CH_UPPER_H = 8'h48;
  localparam logic [7:0] CH_UPPER_R = 8'h52;

  localparam logic [15:0] REQ_STATUS = 16'd5;
  localparam logic [15:0] REQ_POSITION = 16'd6;

  typedef enum logic [1:0] {
    JOB_DISPLAY = 2'd0,
    JOB_STATUS  = 2'd1,
    JOB_CPR     = 2'd2
  } job_kind_t;

  typedef struct packed {
    job_kind_t  kind;
    logic [7:0] data;
    logic [7:0] col;
    logic [7:0] row;
  } job_t;

endpackage

`default_nettype wire

### hdl/aeft_front.sv
// Byte parser: strips escape sequences, tracks the cursor and issues jobs.
// Depends on aeft_pkg.
`timescale 1ns / 1ps
`default_nettype none

module aeft_front import aeft_pkg::*; #(
  parameter int MAX_PARAMS = 16
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_fire,
  input  wire logic [7:0] rx_byte,
  input  wire logic [7:0] screen_columns,
  input  wire logic [7:0] screen_rows,
  output logic            push,
  output job_t            job
);

  localparam int CNT_W = $clog2(MAX_PARAMS + 1);

  typedef enum logic [7:0] {
    M_GROUND    = 8'b0000_0001,
    M_ESC       = 8'b0000_0010,
    M_CSI_FIRST = 8'b0000_0100,
    M_CSI       = 8'b0000_1000,
    M_CSI_SKIP  = 8'b0001_0000,
    M_ESC_SKIP  = 8'b0010_0000,
    M_OSC       = 8'b0100_0000,
    M_OSC_ESC   = 8'b1000_0000
  } mode_t;

  mode_t            mode, mode_next;
  logic [7:0]       col_pos, col_pos_next;
  logic [7:0]       row_pos, row_pos_next;
  logic [15:0]      first_param, first_param_next;
  logic [15:0]      second_param, second_param_next;
  logic [CNT_W-1:0] param_count, param_count_next;
  logic             digit_seen, digit_seen_next;

  logic             body;
  logic             start_csi;
  logic [CNT_W-1:0] cnt_inc;
  logic [CNT_W-1:0] param_total;
  logic [15:0]      acc;
  logic [19:0]      acc_x10;
  logic [15:0]      acc_sat;
  logic [8:0]       col_inc;
  logic             row_can_adv;

  function automatic logic [7:0] clamp_pos(input logic [15:0] v, input logic [7:0] limit);
    logic [15:0] t;
    t = (v == 16'd0) ? 16'd1 : v;
    if (t >= {8'd0, limit}) begin
      return limit - 8'd1;
    end
    return t[7:0];
  endfunction

  assign cnt_inc = param_count + CNT_W'(1);
  assign param_total = param_count + CNT_W'(digit_seen);
  assign acc = (param_count == '0) ? first_param : second_param;
  assign acc_x10 = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {12'd0, rx_byte - CH_ZERO};
  assign acc_sat = (acc_x10[19:16] != 4'd0) ? 16'hFFFF : acc_x10[15:0];
  assign col_inc = {1'b0, col_pos} + 9'd1;
  assign row_can_adv = ({1'b0, row_pos} + 9'd1) < {1'b0, screen_rows};

  always_comb begin
    mode_next = mode;
    col_pos_next = col_pos;
    row_pos_next = row_pos;
    first_param_next = first_param;
    second_param_next = second_param;
    param_count_next = param_count;
    digit_seen_next = digit_seen;
    push = 1'b0;
    job.kind = JOB_DISPLAY;
    job.data = rx_byte;
    body = 1'b0;
    start_csi = 1'b0;

    case (mode)
      M_GROUND: begin
        if (rx_byte == CH_ESC) begin
          mode_next = M_ESC;
        end else if (rx_byte == CH_CSI) begin
          start_csi = 1'b1;
        end else begin
          push = 1'b1;
          if (rx_byte == CH_CR) begin
            col_pos_next = 8'd0;
          end else if (rx_byte == CH_LF) begin
            col_pos_next = 8'd0;
            if (row_can_adv) begin
              row_pos_next = row_pos + 8'd1;
            end
          end else if (col_inc < {1'b0, screen_columns}) begin
            col_pos_next = col_inc[7:0];
          end else begin
            col_pos_next = 8'd0;
            if (row_can_adv) begin
              row_pos_next = row_pos + 8'd1;
            end
          end
        end
      end
      M_ESC: begin
        if (rx_byte == CH_LBRACKET) begin
          start_csi = 1'b1;
        end else if (rx_byte == CH_RBRACKET) begin
          mode_next = M_OSC;
        end else if (rx_byte inside {CH_LPAREN, CH_RPAREN, CH_PERCENT, CH_HASH}) begin
          mode_next = M_ESC_SKIP;
        end else begin
          mode_next = M_GROUND;
        end
      end
      M_CSI_FIRST: begin
        if (rx_byte == CH_LBRACKET) begin
          mode_next = M_CSI_SKIP;
        end else if (rx_byte == CH_QUESTION) begin
          mode_next = M_CSI;
        end else begin
          mode_next = M_CSI;
          body = 1'b1;
        end
      end
      M_CSI: begin
        body = 1'b1;
      end
      M_OSC: begin
        if (rx_byte == CH_BEL) begin
          mode_next = M_GROUND;
        end else if (rx_byte == CH_ESC) begin
          mode_next = M_OSC_ESC;
        end
      end
      M_OSC_ESC: begin
        if (rx_byte == CH_BACKSLASH || rx_byte == CH_BEL) begin
          mode_next = M_GROUND;
        end else if (rx_byte != CH_ESC) begin
          mode_next = M_OSC;
        end
      end
      default: begin
        mode_next = M_GROUND;
      end
    endcase

    if (start_csi) begin
      first_param_next = 16'd0;
      second_param_next = 16'd0;
      param_count_next = '0;
      digit_seen_next = 1'b0;
      mode_next = M_CSI_FIRST;
    end

    if (body) begin
      if (rx_byte == CH_SEMI) begin
        param_count_next = cnt_inc;
        if (cnt_inc >= CNT_W'(MAX_PARAMS)) begin
          mode_next = M_GROUND;
        end else begin
          if (cnt_inc == CNT_W'(1)) begin
            second_param_next = 16'd0;
          end
          digit_seen_next = 1'b0;
        end
      end else if (rx_byte inside {[CH_ZERO:CH_NINE]}) begin
        if (param_count == '0) begin
          first_param_next = acc_sat;
        end else if (param_count == CNT_W'(1)) begin
          second_param_next = acc_sat;
        end
        digit_seen_next = 1'b1;
      end else begin
        mode_next = M_GROUND;
        if (rx_byte == CH_LOWER_N && param_total == CNT_W'(1)) begin
          if (first_param == REQ_STATUS) begin
            push = 1'b1;
            job.kind = JOB_STATUS;
          end else if (first_param == REQ_POSITION) begin
            push = 1'b1;
            job.kind = JOB_CPR;
          end
        end else if (rx_byte == CH_UPPER_H &&
                     (param_total == CNT_W'(1) || param_total == CNT_W'(2))) begin
          row_pos_next = clamp_pos(first_param, screen_rows);
          col_pos_next = clamp_pos((param_total == CNT_W'(2)) ? second_param : 16'd0,
                                   screen_columns);
        end
      end
    end

    job.col = col_pos_next;
    job.row = row_pos_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_GROUND;
      col_pos <= 8'd0;
      row_pos <= 8'd0;
      first_param <= 16'd0;
      second_param <= 16'd0;
      param_count <= '0;
      digit_seen <= 1'b0;
    end else if (in_fire) begin
      mode <= mode_next;
      col_pos <= col_pos_next;
      row_pos <= row_pos_next;
      first_param <= first_param_next;
      second_param <= second_param_next;
      param_count <= param_count_next;
      digit_seen <= digit_seen_next;
    end
  end

endmodule

`default_nettype wire

### hdl/aeft_queue.sv
// Two-entry job queue between the parser and the output sequencer.
// Depends on aeft_pkg.
`timescale 1ns / 1ps
`default_nettype none

module aeft_queue import aeft_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  job_t      job_in,
  output logic      full,
  input  wire logic pop,
  output logic      head_valid,
  output job_t      head
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full = (count == CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= job_in;
    end
  end

endmodule

`default_nettype wire

### hdl/aeft_back.sv
// Output sequencer: expands each job into its result beats.
// Depends on aeft_pkg.
`timescale 1ns / 1ps
`default_nettype none

module aeft_back import aeft_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        head_valid,
  input  job_t             head,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_byte,
  output logic             out_kind,
  output logic             last_of_run,
  output logic [7:0]       cursor_col,
  output logic [7:0]       cursor_row
);

  typedef struct packed {
    logic [2:0][7:0] chars;
    logic [1:0]      len;
  } dec_t;

  logic                      busy;
  logic                      kind;
  logic [IDX_W-1:0]          idx;
  logic [IDX_W-1:0]          last_idx;
  logic [SEQ_LEN-1:0][7:0]   seq;
  logic [7:0]                col;
  logic [7:0]                row;

  logic [SEQ_LEN-1:0][7:0]   seq_next;
  logic [IDX_W-1:0]          last_idx_next;
  dec_t                      row_dec;
  dec_t                      col_dec;
  logic                      out_fire;
  logic                      at_last;

  function automatic dec_t to_dec(input logic [7:0] v);
    dec_t        d;
    logic [1:0]  h;
    logic [7:0]  r;
    logic [15:0] t;
    logic [7:0]  o;
    h = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
    r = v - ({6'd0, h} * 8'd100);
    t = ({8'd0, r} * 16'd205) >> 11;
    o = r - ({4'd0, t[3:0]} * 8'd10);
    d.chars = '0;
    if (v >= 8'd100) begin
      d.len = 2'd3;
      d.chars[0] = CH_ZERO + {6'd0, h};
      d.chars[1] = CH_ZERO + {4'd0, t[3:0]};
      d.chars[2] = CH_ZERO + o;
    end else if (v >= 8'd10) begin
      d.len = 2'd2;
      d.chars[0] = CH_ZERO + {4'd0, t[3:0]};
      d.chars[1] = CH_ZERO + o;
    end else begin
      d.len = 2'd1;
      d.chars[0] = CH_ZERO + o;
    end
    return d;
  endfunction

  assign row_dec = to_dec(head.row + 8'd1);
  assign col_dec = to_dec(head.col + 8'd1);

  always_comb begin
    logic [IDX_W-1:0] kk;
    logic [IDX_W-1:0] nr;
    logic [IDX_W-1:0] nc;
    nr = {2'd0, row_dec.len};
    nc = {2'd0, col_dec.len};
    seq_next = '0;
    last_idx_next = '0;
    case (head.kind)
      JOB_DISPLAY: begin
        seq_next[0] = head.data;
        last_idx_next = IDX_W'(0);
      end
      JOB_STATUS: begin
        seq_next[0] = CH_ESC;
        seq_next[1] = CH_LBRACKET;
        seq_next[2] = CH_ZERO;
        seq_next[3] = CH_LOWER_N;
        last_idx_next = IDX_W'(3);
      end
      JOB_CPR: begin
        for (int k = 0; k < SEQ_LEN; k++) begin
          kk = IDX_W'(k);
          if (kk == IDX_W'(0)) begin
            seq_next[k] = CH_ESC;
          end else if (kk == IDX_W'(1)) begin
            seq_next[k] = CH_LBRACKET;
          end else if (kk < IDX_W'(2) + nr) begin
            seq_next[k] = row_dec.chars[2'(kk - IDX_W'(2))];
          end else if (kk == IDX_W'(2) + nr) begin
            seq_next[k] = CH_SEMI;
          end else if (kk < IDX_W'(3) + nr + nc) begin
            seq_next[k] = col_dec.chars[2'(kk - IDX_W'(3) - nr)];
          end else begin
            seq_next[k] = CH_UPPER_R;
          end
        end
        last_idx_next = IDX_W'(3) + nr + nc;
      end
      default: begin
        seq_next = '0;
        last_idx_next = '0;
      end
    endcase
  end

  assign out_fire = busy && !out_stall;
  assign at_last = (idx == last_idx);
  assign pop = head_valid && (!busy || (out_fire && at_last));

  assign out_valid = busy;
  assign out_byte = seq[idx];
  assign out_kind = kind;
  assign last_of_run = at_last;
  assign cursor_col = col;
  assign cursor_row = row;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx <= '0;
    end else if (pop) begin
      busy <= 1'b1;
      idx <= '0;
    end else if (out_fire) begin
      if (at_last) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      seq <= seq_next;
      last_idx <= last_idx_next;
      kind <= (head.kind != JOB_DISPLAY);
      col <= head.col;
      row <= head.row;
    end
  end

endmodule

`default_nettype wire

### hdl/ansi_escape_filter_cursor_tracker.sv
// Top level of the terminal escape filter with cursor tracker.
// Holds the screen size registers; depends on aeft_pkg, aeft_front, aeft_queue, aeft_back.
//
//   channel | handshake              | payload
//   rx      | rx_valid / rx_stall    | rx_byte
//   out     | out_valid / out_stall  | out_byte, out_kind, last_of_run, cursor_col, cursor_row
//   cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// The parser takes one byte per cycle while rx_stall is low and hands jobs to a
// two-entry queue. A display byte leaves as one beat; a status reply takes 4 beats
// and a position reply 6 to 10 beats, one per cycle while out_stall is low, set by
// the output sequencer. rx_stall rises only while the queue holds two jobs.
// Reset is synchronous; cfg_ready is always high.
`timescale 1ns / 1ps
`default_nettype none

module ansi_escape_filter_cursor_tracker import aeft_pkg::*; #(
  parameter int MAX_PARAMS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   rx_valid,
  output logic                        rx_stall,
  input  wire logic [7:0]             rx_byte,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [7:0]                  out_byte,
  output logic                        out_kind,
  output logic                        last_of_run,
  output logic [7:0]                  cursor_col,
  output logic [7:0]                  cursor_row,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [7:0]             cfg_data
);

  logic [7:0] screen_columns;
  logic [7:0] screen_rows;
  logic [7:0] cfg_value;
  logic       in_fire;
  logic       push;
  logic       full;
  logic       pop;
  logic       head_valid;
  job_t       job;
  job_t       head;

  assign cfg_ready = 1'b1;
  assign cfg_value = (cfg_data == 8'd0) ? 8'd1 : cfg_data;
  assign rx_stall = full;
  assign in_fire = rx_valid && !rx_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_columns <= COLUMNS_RESET;
      screen_rows <= ROWS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SCREEN_COLUMNS: begin
          screen_columns <= cfg_value;
        end
        REG_SCREEN_ROWS: begin
          screen_rows <= cfg_value;
        end
        default: begin
        end
      endcase
    end
  end

  aeft_front #(
    .MAX_PARAMS(MAX_PARAMS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .in_fire        (in_fire),
    .rx_byte        (rx_byte),
    .screen_columns (screen_columns),
    .screen_rows    (screen_rows),
    .push           (push),
    .job            (job)
  );

  aeft_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push && in_fire),
    .job_in     (job),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  aeft_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .out_kind    (out_kind),
    .last_of_run (last_of_run),
    .cursor_col  (cursor_col),
    .cursor_row  (cursor_row)
  );

endmodule

`default_nettype wire
